@@ hdl/u2d_pkg.sv @@
// ----------------------------------------------------------------------------
// u2d_pkg: shared types and constants for the 64-bit binary to decimal text
// converter. Holds the word structs, the cell operation codes and the
// controller states.
// ----------------------------------------------------------------------------
package u2d_pkg;

	localparam int VALUE_W    = 64;
	localparam int SIZE_W     = 8;
	localparam int CHAR_W     = 6;
	localparam int NUM_DIGITS = 20;
	localparam int BITCNT_W   = $clog2(VALUE_W);
	localparam int DIGCNT_W   = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [SIZE_W-1:0]  buffer_size;
	} u2d_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              ok;
		logic              last;
	} u2d_out_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_DABBLE,
		OP_DIGIT
	} u2d_cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} u2d_state_t;

endpackage

@@ hdl/uint64_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// uint64_to_decimal_ascii_top: 64-bit unsigned value to decimal ASCII digits
//
//   channel | signals                       | word
//   --------+-------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data   | value, buffer_size
//   output  | out_valid, out_stall, out_data| digit_char, ok, last
//
// The chain of 20 BCD cells takes one shift-and-correct step for each of the
// 64 input bits. Then leading zero digits are dropped one at a time (up to
// 19), the emit phase follows, and the digits are emitted one at a time,
// held while the output stalls. For a word that fits, dropped zeros and
// emitted digits add up to 20. A word that does not fit the buffer gives its
// single result sooner. Most of the time per word goes to the serial bit
// loop over the chain. A new word is taken only once the last result of the
// previous one sits in the output register. Reset clears control state and
// the chain; a stalled output word holds its value.
// ----------------------------------------------------------------------------
module uint64_to_decimal_ascii_top
	import u2d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  u2d_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output u2d_out_t out_data
);

	u2d_state_t state_q, state_d;

	logic [VALUE_W-1:0]  value_q;
	logic [SIZE_W-1:0]   size_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [DIGCNT_W-1:0] cnt_q;
	logic                out_valid_q;
	u2d_out_t            out_q;

	u2d_cell_op_t        cell_op;
	logic [3:0]          digit [NUM_DIGITS];
	logic                carry [NUM_DIGITS];
	logic [3:0]          top_digit;

	logic in_take;
	logic slot_free;
	logic fail;
	logic load_out;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign top_digit = digit[NUM_DIGITS-1];
	// fail when the buffer cannot hold the digits and a terminator
	assign fail      = size_q <= {{(SIZE_W-DIGCNT_W){1'b0}}, cnt_q};

	genvar gi;
	generate
		for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
			logic       cin;
			logic [3:0] din;
			if (gi == 0) begin : g_low
				assign cin = value_q[VALUE_W-1];
				assign din = 4'd0;
			end else begin : g_mid
				assign cin = carry[gi-1];
				assign din = digit[gi-1];
			end
			if (gi == NUM_DIGITS - 1) begin : g_top
				u2d_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.op        (cell_op),
					.carry_in  (cin),
					.digit_in  (din),
					.carry_out (),
					.digit     (digit[gi])
				);
				assign carry[gi] = 1'b0;
			end else begin : g_chain
				u2d_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.op        (cell_op),
					.carry_in  (cin),
					.digit_in  (din),
					.carry_out (carry[gi]),
					.digit     (digit[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		state_d  = state_q;
		cell_op  = OP_HOLD;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					cell_op = OP_CLEAR;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_op = OP_DABBLE;
				if (bit_cnt_q == BITCNT_W'(VALUE_W - 1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (top_digit == 4'd0 && cnt_q != DIGCNT_W'(1)) begin
					cell_op = OP_DIGIT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (fail) begin
						state_d = ST_IDLE;
					end else begin
						cell_op = OP_DIGIT;
						if (cnt_q == DIGCNT_W'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				bit_cnt_q <= '0;
				cnt_q     <= DIGCNT_W'(NUM_DIGITS);
			end else if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end else if (cell_op == OP_DIGIT) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= in_data.value;
			size_q  <= in_data.buffer_size;
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
		if (load_out) begin
			if (fail) begin
				out_q.digit_char <= '0;
				out_q.ok         <= 1'b0;
				out_q.last       <= 1'b1;
			end else begin
				out_q.digit_char <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
				out_q.ok         <= 1'b1;
				out_q.last       <= (cnt_q == DIGCNT_W'(1));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/u2d_cell.sv @@
// ----------------------------------------------------------------------------
// u2d_cell: one decimal digit of the conversion chain
// Holds a BCD digit. In dabble mode it corrects and shifts in one bit from
// the cell below, handing its top bit to the cell above. In digit mode it
// takes the whole digit of the cell below, so digits move out at the top.
// ----------------------------------------------------------------------------
module u2d_cell
	import u2d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  u2d_cell_op_t op,
	input  logic         carry_in,
	input  logic [3:0]   digit_in,
	output logic         carry_out,
	output logic [3:0]   digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add three before the shift when the digit would pass nine
	assign adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else begin
			unique case (op)
				OP_HOLD:   digit_q <= digit_q;
				OP_CLEAR:  digit_q <= 4'd0;
				OP_DABBLE: digit_q <= {adj[2:0], carry_in};
				OP_DIGIT:  digit_q <= digit_in;
				default:   digit_q <= digit_q;
			endcase
		end
	end

endmodule

@@ tb/tb_uint64_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// tb_uint64_to_decimal_ascii_top: self-checking bench for the decimal converter
//
// Sends 64-bit values with buffer sizes: a directed set of edge values first,
// then random values spread over every digit count, with sizes mostly around the
// fit boundary. Each accepted word is expanded into its expected digit
// characters. Output words are compared field by field in order. The sender
// idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_uint64_to_decimal_ascii_top;
	import u2d_pkg::*;

	localparam int  MIN_BUFFER   = 2;
	localparam int  RANDOM_WORDS = 300;
	localparam int  DRAIN_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 1000000;

	class decimal_text_scoreboard;
		u2d_out_t expected_chars[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void push_char(logic [CHAR_W-1:0] ch, logic ok, logic last);
			u2d_out_t r;
			r.digit_char = ch;
			r.ok         = ok;
			r.last       = last;
			expected_chars.push_back(r);
		endfunction

		// expand one accepted word into its digit characters
		function void note_word(u2d_in_t w);
			logic [VALUE_W-1:0] v;
			logic [3:0]         digs[NUM_DIGITS];
			int unsigned        n;
			v = w.value;
			n = 0;
			if (w.buffer_size < MIN_BUFFER) begin
				push_char('0, 1'b0, 1'b1);
				return;
			end
			if (v == '0) begin
				push_char(ASCII_ZERO, 1'b1, 1'b1);
				return;
			end
			while (v != '0) begin
				digs[n] = 4'(v % 10);
				v = v / 10;
				n++;
			end
			// room for every digit plus the terminator
			if (w.buffer_size < n + 1) begin
				push_char('0, 1'b0, 1'b1);
				return;
			end
			for (int i = n - 1; i >= 0; i--)
				push_char(ASCII_ZERO + CHAR_W'(digs[i]), 1'b1, i == 0);
		endfunction

		task check_char(u2d_out_t got);
			u2d_out_t exp_c;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected word char=%0d ok=%0b last=%0b",
					got.digit_char, got.ok, got.last));
				return;
			end
			exp_c = expected_chars.pop_front();
			if (got.digit_char !== exp_c.digit_char)
				report_mismatch($sformatf("digit_char got %0d want %0d",
					got.digit_char, exp_c.digit_char));
			if (got.ok !== exp_c.ok)
				report_mismatch($sformatf("ok got %0b want %0b", got.ok, exp_c.ok));
			if (got.last !== exp_c.last)
				report_mismatch($sformatf("last got %0b want %0b", got.last, exp_c.last));
		endtask

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	u2d_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	u2d_out_t out_data;

	decimal_text_scoreboard sb = new();

	int     burst_left = 0;
	int     stall_mode = 0;
	int     mode_left = 0;
	int     run_left = 0;
	longint cycle_cnt = 0;

	uint64_to_decimal_ascii_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_uint64_to_decimal_ascii_top: done, errors");
			$finish;
		end
	end

	// receiver: check accepted words, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_char(out_data);
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				// long runs of stall and no stall
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left = $urandom_range(1, 16);
				end else begin
					run_left--;
				end
			end
		endcase
	end

	task automatic send_word(input u2d_in_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 6);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		// hold the word until it is taken
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
		burst_left--;
	endtask

	task automatic send_pair(input logic [VALUE_W-1:0] v, input logic [SIZE_W-1:0] size);
		u2d_in_t w;
		w.value       = v;
		w.buffer_size = size;
		send_word(w);
	endtask

	function automatic int digit_count(logic [VALUE_W-1:0] v);
		int n;
		n = 1;
		while (v >= 10) begin
			v = v / 10;
			n++;
		end
		return n;
	endfunction

	function automatic u2d_in_t random_word();
		u2d_in_t            w;
		logic [VALUE_W-1:0] v;
		int                 n;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = v >> $urandom_range(0, 63);
			6: begin
				// power of ten, or one below it
				v = 64'd1;
				repeat ($urandom_range(0, 19)) v = v * 64'd10;
				if ($urandom_range(0, 1)) v = v - 64'd1;
			end
			7: ;
			default: v = VALUE_W'($urandom_range(0, 20));
		endcase
		n = digit_count(v);
		case ($urandom_range(0, 7))
			0, 1, 2: w.buffer_size = SIZE_W'(n + 1);
			3:       w.buffer_size = SIZE_W'(n);
			4:       w.buffer_size = SIZE_W'(n + 1 + $urandom_range(0, 3));
			5:       w.buffer_size = SIZE_W'($urandom_range(0, 255));
			6:       w.buffer_size = SIZE_W'($urandom_range(0, 1));
			default: w.buffer_size = SIZE_W'($urandom_range(21, 255));
		endcase
		w.value = v;
		return w;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_pair(64'd0, 8'd0);
		send_pair(64'd0, 8'd1);
		send_pair(64'd0, 8'd2);
		send_pair(64'd0, 8'd255);
		send_pair(64'd5, 8'd1);
		send_pair(64'd9, 8'd2);
		send_pair(64'd10, 8'd2);
		send_pair(64'd10, 8'd3);
		send_pair(64'd1, 8'd255);
		send_pair(64'hFFFF_FFFF_FFFF_FFFF, 8'd20);
		send_pair(64'hFFFF_FFFF_FFFF_FFFF, 8'd21);
		send_pair(64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
		send_pair(64'd10000000000000000000, 8'd20);
		send_pair(64'd10000000000000000000, 8'd21);
		send_pair(64'd9999999999999999999, 8'd19);
		send_pair(64'd9999999999999999999, 8'd20);
		send_pair(64'h8000_0000_0000_0000, 8'd128);
		send_pair(64'h5555_5555_5555_5555, 8'd21);
		send_pair(64'hAAAA_AAAA_AAAA_AAAA, 8'd200);
		send_pair(64'd1234567890, 8'd10);
		send_pair(64'd1234567890, 8'd11);
		send_pair(64'd99, 8'd255);

		repeat (RANDOM_WORDS) send_word(random_word());
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		// catch any stray word after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_uint64_to_decimal_ascii_top: done, clean");
		else
			$display("tb_uint64_to_decimal_ascii_top: done, errors");
		$finish;
	end

endmodule

@@ uint64_to_decimal_ascii_top.f @@
hdl/u2d_pkg.sv
hdl/u2d_cell.sv
hdl/uint64_to_decimal_ascii_top.sv
tb/tb_uint64_to_decimal_ascii_top.sv
